// ===== hw/rtl/ufc_pkg.sv =====
// shared types and constants of the upwind face coefficient pipeline
package ufc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned W1_QBITS  = DATA_W - 1;      // quotient bits of the width divide
  localparam int unsigned W2_QBITS  = WEIGHT_BITS + 1; // quotient bits of the weight divide

  localparam logic [1:0] MODE_SKIP  = 2'd0;
  localparam logic [1:0] MODE_C0    = 2'd1;
  localparam logic [1:0] MODE_C1    = 2'd2;
  localparam logic [1:0] MODE_BLEND = 2'd3;

  localparam logic [W2_QBITS-1:0] WEIGHT_HALF = W2_QBITS'(1) << (WEIGHT_BITS - 1);

  typedef struct packed {
    logic [1:0]               mode;
    logic                     sum_zero;
    logic signed [DATA_W:0]   d;
    logic signed [DATA_W-1:0] c0;
    logic signed [DATA_W-1:0] c1;
  } ctl_t;

endpackage

// ===== hw/rtl/ufc_if.sv =====
// word channels of the upwind face coefficient block
interface ufc_in_if;
  logic        valid;
  logic        ready;
  logic        one_sided;
  logic        has_face_potential;
  logic signed [31:0] first_potential;
  logic signed [31:0] second_potential;
  logic signed [31:0] face_potential;
  logic signed [31:0] first_overlap;
  logic signed [31:0] second_overlap;
  logic signed [31:0] first_coef;
  logic signed [31:0] second_coef;

  modport source (output valid, one_sided, has_face_potential, first_potential,
                  second_potential, face_potential, first_overlap, second_overlap,
                  first_coef, second_coef, input ready);
  modport sink (input valid, one_sided, has_face_potential, first_potential,
                second_potential, face_potential, first_overlap, second_overlap,
                first_coef, second_coef, output ready);
endinterface

interface ufc_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] face_coefficient;
  logic        write_enable;

  modport source (output valid, face_coefficient, write_enable, input ready);
  modport sink (input valid, face_coefficient, write_enable, output ready);
endinterface

// ===== hw/rtl/upwind_face_coefficient.sv =====
// top level: pipelined smoothed upwind face coefficient
// One face word enters per clock and one result word leaves per clock while results
// are taken. A word passes 53 register stages on its way to the output register: an
// input register, a 31x31 product stage, 31 one-bit restoring steps for the smoothing
// width W = a*b/(a+b), a band decision stage, 17 one-bit steps for the Q1.16 blend
// weight, a 33x18 blend multiply and the output register. The whole pipeline moves
// together; it holds when the output register is full and not taken, so no word is
// lost or repeated. Boundary faces and faces outside the smoothing band ride the same
// stages so results leave in order. No reset sweep; ready is high from the first cycle
// after reset.
module upwind_face_coefficient (
  input  logic clk,
  input  logic rst_n,
  ufc_in_if.sink    in_ch,
  ufc_out_if.source out_ch
);

  localparam int unsigned DW = ufc_pkg::DATA_W;
  localparam int unsigned Q1 = ufc_pkg::W1_QBITS;
  localparam int unsigned Q2 = ufc_pkg::W2_QBITS;

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // input register
  logic a_v_r;
  logic a_os_r, a_hf_r;
  logic signed [DW-1:0] a_p0_r, a_p1_r, a_pf_r, a_o0_r, a_o1_r, a_c0_r, a_c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_ch.valid;
    if (en) begin
      a_os_r <= in_ch.one_sided;
      a_hf_r <= in_ch.has_face_potential;
      a_p0_r <= in_ch.first_potential;
      a_p1_r <= in_ch.second_potential;
      a_pf_r <= in_ch.face_potential;
      a_o0_r <= in_ch.first_overlap;
      a_o1_r <= in_ch.second_overlap;
      a_c0_r <= in_ch.first_coef;
      a_c1_r <= in_ch.second_coef;
    end
  end

  // clamp overlaps, product and sum, boundary decision
  logic [DW-2:0]   ca, cb;
  logic [2*DW-3:0] prod;
  logic [DW-1:0]   sum;
  ufc_pkg::ctl_t   b_ctl;

  always_comb begin
    ca   = a_o0_r[DW-1] ? '0 : a_o0_r[DW-2:0];
    cb   = a_o1_r[DW-1] ? '0 : a_o1_r[DW-2:0];
    prod = ca * cb;
    sum  = {1'b0, ca} + {1'b0, cb};
    b_ctl.c0 = a_c0_r;
    b_ctl.c1 = a_c1_r;
    b_ctl.d  = {a_p1_r[DW-1], a_p1_r} - {a_p0_r[DW-1], a_p0_r};
    b_ctl.sum_zero = (sum == '0);
    if (a_os_r) begin
      b_ctl.mode = (!a_hf_r || a_p0_r >= a_pf_r) ? ufc_pkg::MODE_C0 : ufc_pkg::MODE_SKIP;
    end else begin
      b_ctl.mode = ufc_pkg::MODE_BLEND;
    end
  end

  // width divider: stage 0 is loaded here, each following stage retires one bit
  logic            v1_r   [0:Q1];
  ufc_pkg::ctl_t   ctl1_r [0:Q1];
  logic [DW-1:0]   rem1_r [0:Q1];
  logic [DW-1:0]   dvs1_r [0:Q1];
  logic [Q1-1:0]   low1_r [0:Q1];
  logic [Q1-1:0]   quo1_r [0:Q1];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r[0] <= 1'b0;
    else if (en) v1_r[0] <= a_v_r;
    if (en) begin
      ctl1_r[0] <= b_ctl;
      rem1_r[0] <= {1'b0, prod[2*DW-3:Q1]};
      low1_r[0] <= prod[Q1-1:0];
      dvs1_r[0] <= sum;
      quo1_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < Q1; i++) begin : g_div1
    logic [DW:0] tmp;
    logic        ge;
    always_comb begin
      tmp = {rem1_r[i], low1_r[i][Q1-1]};
      ge  = tmp >= {1'b0, dvs1_r[i]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v1_r[i+1] <= 1'b0;
      else if (en) v1_r[i+1] <= v1_r[i];
      if (en) begin
        ctl1_r[i+1] <= ctl1_r[i];
        dvs1_r[i+1] <= dvs1_r[i];
        rem1_r[i+1] <= ge ? DW'(tmp - {1'b0, dvs1_r[i]}) : tmp[DW-1:0];
        low1_r[i+1] <= {low1_r[i][Q1-2:0], 1'b0};
        quo1_r[i+1] <= {quo1_r[i][Q1-2:0], ge};
      end
    end
  end

  // band decision and weight divider setup
  logic [Q1-1:0]        wq;
  logic signed [DW+1:0] dx, wx, dw;
  ufc_pkg::ctl_t        c_ctl;
  logic                 c_half;

  always_comb begin
    wq = (ctl1_r[Q1].sum_zero || quo1_r[Q1] == '0) ? Q1'(1) : quo1_r[Q1];
    dx = {ctl1_r[Q1].d[DW], ctl1_r[Q1].d};
    wx = {3'b000, wq};
    dw = dx + wx;
    c_ctl  = ctl1_r[Q1];
    c_half = (wq < Q1'(2));
    if (ctl1_r[Q1].mode == ufc_pkg::MODE_BLEND) begin
      if (-dx > wx)     c_ctl.mode = ufc_pkg::MODE_C0;
      else if (dx > wx) c_ctl.mode = ufc_pkg::MODE_C1;
    end
  end

  logic            v2_r    [0:Q2];
  ufc_pkg::ctl_t   ctl2_r  [0:Q2];
  logic            half2_r [0:Q2];
  logic [DW-1:0]   rem2_r  [0:Q2];
  logic [DW-1:0]   dvs2_r  [0:Q2];
  logic [Q2-1:0]   low2_r  [0:Q2];
  logic [Q2-1:0]   quo2_r  [0:Q2];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r[0] <= 1'b0;
    else if (en) v2_r[0] <= v1_r[Q1];
    if (en) begin
      ctl2_r[0]  <= c_ctl;
      half2_r[0] <= c_half;
      rem2_r[0]  <= dw[DW:1];
      low2_r[0]  <= {dw[0], (Q2-1)'(0)};
      dvs2_r[0]  <= {wq, 1'b0};
      quo2_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < Q2; j++) begin : g_div2
    logic [DW:0] tmp;
    logic        ge;
    always_comb begin
      tmp = {rem2_r[j], low2_r[j][Q2-1]};
      ge  = tmp >= {1'b0, dvs2_r[j]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v2_r[j+1] <= 1'b0;
      else if (en) v2_r[j+1] <= v2_r[j];
      if (en) begin
        ctl2_r[j+1]  <= ctl2_r[j];
        half2_r[j+1] <= half2_r[j];
        dvs2_r[j+1]  <= dvs2_r[j];
        rem2_r[j+1]  <= ge ? DW'(tmp - {1'b0, dvs2_r[j]}) : tmp[DW-1:0];
        low2_r[j+1]  <= {low2_r[j][Q2-2:0], 1'b0};
        quo2_r[j+1]  <= {quo2_r[j][Q2-2:0], ge};
      end
    end
  end

  // blend multiply: (c1 - c0) * weight
  logic [Q2-1:0]          wt;
  logic signed [DW:0]     diff;
  logic                   m_v_r;
  ufc_pkg::ctl_t          m_ctl_r;
  logic signed [DW+Q2:0]  m_prod_r;

  always_comb begin
    wt   = half2_r[Q2] ? ufc_pkg::WEIGHT_HALF : quo2_r[Q2];
    diff = {ctl2_r[Q2].c1[DW-1], ctl2_r[Q2].c1} - {ctl2_r[Q2].c0[DW-1], ctl2_r[Q2].c0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (en) m_v_r <= v2_r[Q2];
    if (en) begin
      m_ctl_r  <= ctl2_r[Q2];
      m_prod_r <= diff * $signed({1'b0, wt});
    end
  end

  // round half up, add back c0, select by mode
  logic signed [DW+Q2:0] acc;
  logic signed [DW+Q2:0] blend;
  logic signed [DW-1:0]  res;
  logic                  res_we;

  always_comb begin
    acc   = m_prod_r + (DW+Q2+1)'(ufc_pkg::WEIGHT_HALF);
    blend = (acc >>> ufc_pkg::WEIGHT_BITS) + {{(Q2+1){m_ctl_r.c0[DW-1]}}, m_ctl_r.c0};
    res_we = 1'b1;
    case (m_ctl_r.mode)
      ufc_pkg::MODE_C0: res = m_ctl_r.c0;
      ufc_pkg::MODE_C1: res = m_ctl_r.c1;
      ufc_pkg::MODE_BLEND: res = blend[DW-1:0];
      default: begin
        res    = '0;
        res_we = 1'b0;
      end
    endcase
  end

  // output register
  logic signed [DW-1:0] out_coef_r;
  logic                 out_we_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= m_v_r;
    if (en) begin
      out_coef_r <= res;
      out_we_r   <= res_we;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.face_coefficient = out_coef_r;
  assign out_ch.write_enable     = out_we_r;

endmodule

// ===== hw/rtl/ufc_checker.sv =====
// port checker for the upwind face coefficient block
module ufc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_coef,
  input logic        out_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_coef) && $stable(out_we))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_we |-> out_coef == 32'd0)
    else $error("skipped face carries nonzero coefficient");

endmodule

bind upwind_face_coefficient ufc_checker u_ufc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_coef  (out_ch.face_coefficient),
  .out_we    (out_ch.write_enable)
);

// ===== tb/ufc_tb_if.sv =====
`timescale 1ns / 1ps
// testbench word types of the upwind face coefficient channels
package ufc_tb_pkg;

  typedef struct {
    logic        one_sided;
    logic        has_face_potential;
    logic signed [31:0] first_potential;
    logic signed [31:0] second_potential;
    logic signed [31:0] face_potential;
    logic signed [31:0] first_overlap;
    logic signed [31:0] second_overlap;
    logic signed [31:0] first_coef;
    logic signed [31:0] second_coef;
  } face_word_t;

  typedef struct {
    logic signed [31:0] face_coefficient;
    logic               write_enable;
  } coef_word_t;
endpackage

// ===== tb/tb_upwind_face_coefficient.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the upwind face coefficient pipeline
module tb_upwind_face_coefficient;

  logic clk;
  logic rst_n;

  ufc_in_if  in_ch ();
  ufc_out_if out_ch ();

  upwind_face_coefficient dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // idle percentages of sender and receiver, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  ufc_tb_pkg::coef_word_t  expected_coefs[$];

  localparam int DATA_MIN = int'(32'h8000_0000);
  localparam int DATA_MAX = 2147483647;

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // face coefficient predictor, raw fixed-point arithmetic on 64-bit values
  function automatic ufc_tb_pkg::coef_word_t predict_face_coef(ufc_tb_pkg::face_word_t f);
    ufc_tb_pkg::coef_word_t r;
    longint p0, p1, pf, ol0, ol1, c0, c1, d, width, wt, acc;
    longint unsigned num;
    p0  = f.first_potential;
    p1  = f.second_potential;
    pf  = f.face_potential;
    ol0 = f.first_overlap;
    ol1 = f.second_overlap;
    c0  = f.first_coef;
    c1  = f.second_coef;
    r.face_coefficient = '0;
    r.write_enable     = 1'b1;
    if (f.one_sided) begin
      // boundary face: copy unless a face potential is given and is higher
      if (!f.has_face_potential || p0 >= pf) r.face_coefficient = c0[31:0];
      else r.write_enable = 1'b0;
      return r;
    end
    if (ol0 < 0) ol0 = 0;
    if (ol1 < 0) ol1 = 0;
    width = 0;
    if (ol0 + ol1 != 0) width = (ol0 * ol1) / (ol0 + ol1);
    if (width < 1) width = 1;  // smoothing width never below one lsb
    d = p1 - p0;
    if (-d > width) acc = c0;
    else if (d > width) acc = c1;
    else begin
      if (width < 2) wt = 32768;
      else begin
        num = longint'(d + width) << 16;
        wt  = longint'(num / longint'(width * 2));
        if (wt > 65536) wt = 65536;
      end
      acc = c1 * wt + c0 * (65536 - wt) + 32768;
      acc = acc >>> 16;  // arithmetic shift is a floor
    end
    if (acc > DATA_MAX) acc = DATA_MAX;
    if (acc < DATA_MIN) acc = DATA_MIN;
    r.face_coefficient = acc[31:0];
    return r;
  endfunction

  // send one face word, idling first at the current rate
  task automatic send_face(ufc_tb_pkg::face_word_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.one_sided          <= f.one_sided;
    in_ch.has_face_potential <= f.has_face_potential;
    in_ch.first_potential    <= f.first_potential;
    in_ch.second_potential   <= f.second_potential;
    in_ch.face_potential     <= f.face_potential;
    in_ch.first_overlap      <= f.first_overlap;
    in_ch.second_overlap     <= f.second_overlap;
    in_ch.first_coef         <= f.first_coef;
    in_ch.second_coef        <= f.second_coef;
    do @(posedge clk); while (!in_ch.ready);
    expected_coefs.push_back(predict_face_coef(f));
  endtask

  // receiver: random stalls, compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    ufc_tb_pkg::coef_word_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_coefs.size() == 0) begin
          $display("%0t: unexpected word coef=%0d we=%0b", $time,
                   out_ch.face_coefficient, out_ch.write_enable);
          error_count++;
        end else begin
          exp_w = expected_coefs.pop_front();
          if (out_ch.face_coefficient !== exp_w.face_coefficient) begin
            $display("%0t: face_coefficient expected %0d actual %0d", $time,
                     exp_w.face_coefficient, out_ch.face_coefficient);
            error_count++;
          end
          if (out_ch.write_enable !== exp_w.write_enable) begin
            $display("%0t: write_enable expected %0b actual %0b", $time,
                     exp_w.write_enable, out_ch.write_enable);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic ufc_tb_pkg::face_word_t make_face(int os, int hf, int p0, int p1,
                                                       int pf, int ol0, int ol1,
                                                       int c0, int c1);
    ufc_tb_pkg::face_word_t f;
    f.one_sided = os[0]; f.has_face_potential = hf[0];
    f.first_potential = p0; f.second_potential = p1; f.face_potential = pf;
    f.first_overlap = ol0; f.second_overlap = ol1;
    f.first_coef = c0; f.second_coef = c1;
    return f;
  endfunction

  // random face: mostly near-band potentials with small widths so blends are frequent
  function automatic ufc_tb_pkg::face_word_t random_face();
    ufc_tb_pkg::face_word_t f;
    int span;
    f.one_sided          = ($urandom_range(3) == 0);
    f.has_face_potential = 1'($urandom_range(1));
    f.first_potential    = $urandom;
    f.face_potential     = ($urandom_range(1)) ? $urandom : f.first_potential + $urandom_range(4) - 2;
    f.first_overlap      = $urandom;
    f.second_overlap     = $urandom;
    f.first_coef         = $urandom;
    f.second_coef        = $urandom;
    case ($urandom_range(3))
      0: span = 32'h7fffffff;
      1: span = 1 << $urandom_range(30);
      default: span = $urandom_range(1 << 20);
    endcase
    if ($urandom_range(3) != 0) begin
      f.first_overlap  = $urandom_range(span);
      f.second_overlap = $urandom_range(span);
      f.first_potential = $signed($urandom) >>> 2;
      f.second_potential = f.first_potential + $signed($urandom_range(span)) - span / 2;
    end else begin
      f.second_potential = $urandom;
    end
    return f;
  endfunction

  task automatic test_boundary_faces();
    send_face(make_face(1, 0, 5, 0, 9, 0, 0, DATA_MAX, 0));
    send_face(make_face(1, 1, 9, 0, 9, 0, 0, DATA_MIN, 7));      // equal potentials copy
    send_face(make_face(1, 1, 8, 0, 9, 0, 0, 123, 7));           // failed comparison
    send_face(make_face(1, 1, DATA_MIN, DATA_MAX, DATA_MAX, -1, -1, -1, -1));
    send_face(make_face(1, 1, DATA_MAX, 3, DATA_MIN, DATA_MAX, 3, 77, 1));
  endtask

  task automatic test_two_cell_faces();
    // both widths non-positive: half weight
    send_face(make_face(0, 1, 0, 1, DATA_MAX, DATA_MIN, -5, 10, 20));
    send_face(make_face(0, 0, 0, 0, 0, 0, 0, DATA_MIN, DATA_MAX));
    // one width non-positive
    send_face(make_face(0, 0, 0, -1, 0, 1000, 0, 3, 4));
    // far outside the band in each direction, then extreme overlaps and coefficients inside it
    send_face(make_face(0, 0, DATA_MIN, DATA_MAX, 0, 4, 4, 11, 22));
    send_face(make_face(0, 0, DATA_MAX, DATA_MIN, 0, 4, 4, 11, 22));
    send_face(make_face(0, 0, DATA_MAX, DATA_MAX, 0, DATA_MAX, DATA_MAX, DATA_MIN, DATA_MAX));
    // band edges with width 2, then blends inside wide bands
    send_face(make_face(0, 0, 0, 2, 0, 4, 4, 0, 65536));
    send_face(make_face(0, 0, 0, -2, 0, 4, 4, 0, 65536));
    send_face(make_face(0, 0, 0, 3, 0, 4, 4, 0, 65536));
    send_face(make_face(0, 0, 100, 101, 0, DATA_MAX, DATA_MAX - 1, DATA_MIN, DATA_MAX));
    send_face(make_face(0, 1, -7, -9, 3, 65536, 196608, -300000, 5000000));
  endtask

  task automatic test_random_faces(int n);
    repeat (n) send_face(random_face());
  endtask

  // wait for every expected word, then for the pipeline latency
  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (expected_coefs.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  initial begin
    error_count   = 0;
    send_idle_pct = 37;
    recv_idle_pct = 77;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.one_sided <= 1'b0;
    in_ch.has_face_potential <= 1'b0;
    in_ch.first_potential <= '0;
    in_ch.second_potential <= '0;
    in_ch.face_potential <= '0;
    in_ch.first_overlap <= '0;
    in_ch.second_overlap <= '0;
    in_ch.first_coef <= '0;
    in_ch.second_coef <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_boundary_faces();
    test_two_cell_faces();
    test_random_faces(330);
    send_idle_pct = 77;
    recv_idle_pct = 37;
    test_random_faces(340);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_faces(364);
    drain();

    if (error_count == 0 && expected_coefs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
